### hw/rtl/line_pixel_generator_defines.svh
// ---------------------------------------------------------------------------
// line_pixel_generator_defines
// Assertion macros used by the checker of the line pixel generator.
// ---------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// Checked on every rising edge outside reset.
`define LPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/lpg_pkg.sv
// ---------------------------------------------------------------------------
// lpg_pkg
// Types, widths and helpers shared by the line pixel generator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

  localparam int COORD_BITS    = 8;
  localparam int D_BITS        = COORD_BITS + 3;
  localparam int FIELD_BITS    = 8;
  localparam int COLOUR_BITS   = 16;
  localparam int IN_DATA_BITS  = 4 * FIELD_BITS + COLOUR_BITS;
  localparam int OUT_DATA_BITS = 2 * FIELD_BITS + COLOUR_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic signed [D_BITS-1:0] dterm_t;
  typedef logic [COLOUR_BITS-1:0] colour_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // one classified transaction, as handed from front to back
  typedef struct packed {
    action_t action;
    coord_t  x0;
    coord_t  y0;
    coord_t  major_end;
    coord_t  major_delta;
    coord_t  minor_delta;
    logic    steep;
    logic    minor_neg;
    dterm_t  d0;
    colour_t colour;
  } cmd_t;

  function automatic coord_t to_coord(input logic [FIELD_BITS-1:0] f);
    return COORD_BITS'(f);
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input coord_t c);
    return FIELD_BITS'(c);
  endfunction

  // 2*v, zero extended to the decision term width
  function automatic dterm_t twice(input coord_t v);
    return $signed({2'b00, v, 1'b0});
  endfunction

endpackage

`default_nettype wire

### hw/rtl/line_pixel_generator.sv
// ---------------------------------------------------------------------------
// line_pixel_generator
// Bresenham line rasteriser producing one result per start or step transaction.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser is the action (0 start, 1 step). A start carries
//   both endpoints and the RGB565 colour in s_tdata and yields the first
//   pixel; each step yields the next pixel. A step with no line running
//   yields a result with pixel_valid low and all other fields zero.
//   Output stream m_*: one result per input transaction, in order.
//   m_tuser is pixel_valid, m_tlast marks the final pixel of the line.
// Timing:
//   An accepted input is written into the queue, then the back's step takes it
//   into the output register. While m_tready stays high the sustained rate is one
//   transaction per cycle, set by the back's single add-and-compare step on
//   the decision term.
// Reset (rst, synchronous): queue emptied, no line running, output idle.
// Stall: while m_tready is low the output register holds; the two-entry
//   command queue keeps accepting until full, then s_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module line_pixel_generator
  import lpg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // start_x, start_y, end_x, end_y, colour
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
  // action
  input  wire logic                     s_tuser,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // pixel_x, pixel_y, pixel_colour
  output logic [OUT_DATA_BITS-1:0]      m_tdata,
  // pixel_valid
  output logic                          m_tuser,
  // last_pixel
  output logic                          m_tlast
);

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, pop_valid;

  lpg_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  lpg_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  lpg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

### hw/rtl/lpg_front.sv
// ---------------------------------------------------------------------------
// lpg_front
// Accepts input transactions and works out the line setup: major axis,
// endpoint swap, deltas and initial decision term.
// ---------------------------------------------------------------------------
`default_nettype none

module lpg_front
  import lpg_pkg::*;
(
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // start_x, start_y, end_x, end_y, colour
  input  wire logic [IN_DATA_BITS-1:0] s_tdata,
  // action
  input  wire logic                    s_tuser,
  input  wire logic                    q_full,
  output logic                         q_push,
  output cmd_t                         q_cmd
);

  coord_t ax, ay, bx, by;
  coord_t adx, ady;
  coord_t sx0, sy0, sx1, sy1;
  coord_t major, minor;
  logic   steep, swap;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    ax    = to_coord(s_tdata[FIELD_BITS-1:0]);
    ay    = to_coord(s_tdata[2*FIELD_BITS-1:FIELD_BITS]);
    bx    = to_coord(s_tdata[3*FIELD_BITS-1:2*FIELD_BITS]);
    by    = to_coord(s_tdata[4*FIELD_BITS-1:3*FIELD_BITS]);
    adx   = (bx > ax) ? bx - ax : ax - bx;
    ady   = (by > ay) ? by - ay : ay - by;
    steep = !(ady < adx);
    swap  = steep ? (ay > by) : (ax > bx);
    sx0   = swap ? bx : ax;
    sy0   = swap ? by : ay;
    sx1   = swap ? ax : bx;
    sy1   = swap ? ay : by;
    major = steep ? ady : adx;
    minor = steep ? adx : ady;

    q_cmd.action      = action_t'(s_tuser);
    q_cmd.x0          = sx0;
    q_cmd.y0          = sy0;
    q_cmd.major_end   = steep ? sy1 : sx1;
    q_cmd.major_delta = major;
    q_cmd.minor_delta = minor;
    q_cmd.steep       = steep;
    q_cmd.minor_neg   = steep ? (sx1 < sx0) : (sy1 < sy0);
    q_cmd.d0          = twice(minor) - $signed({3'b000, major});
    q_cmd.colour      = s_tdata[IN_DATA_BITS-1:4*FIELD_BITS];
  end

endmodule

`default_nettype wire

### hw/rtl/lpg_cmd_queue.sv
// ---------------------------------------------------------------------------
// lpg_cmd_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module lpg_cmd_queue
  import lpg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output cmd_t      pop_cmd
);

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push, do_pop;

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lpg_back.sv
// ---------------------------------------------------------------------------
// lpg_back
// Holds the line state, runs one Bresenham step per command and drives the
// registered pixel output.
// ---------------------------------------------------------------------------
`default_nettype none

module lpg_back
  import lpg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     q_valid,
  input  wire cmd_t                     q_cmd,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // pixel_x, pixel_y, pixel_colour
  output logic [OUT_DATA_BITS-1:0]      m_tdata,
  // pixel_valid
  output logic                          m_tuser,
  // last_pixel
  output logic                          m_tlast
);

  // line state
  logic    line_active;
  logic    steep_line;
  coord_t  cur_x, cur_y;
  coord_t  major_end, major_delta, minor_delta;
  logic    minor_step_negative;
  dterm_t  decision_term;
  colour_t line_colour;

  // output register
  logic    q_valid_out;
  coord_t  out_x, out_y;
  colour_t out_colour;
  logic    out_pix, out_last;

  // working values: the loaded setup on a start, the held state otherwise
  logic    is_start, act, stp, neg, last, bump;
  coord_t  wx, wy, wend, wmaj, wmin, major_cur;
  coord_t  x_next, y_next;
  dterm_t  wd, d_next;
  colour_t wcol;

  assign q_pop    = q_valid && (!m_tvalid || m_tready);
  assign m_tvalid = q_valid_out;
  assign m_tdata  = {out_colour, to_field(out_y), to_field(out_x)};
  assign m_tuser  = out_pix;
  assign m_tlast  = out_last;

  always_comb begin
    is_start  = (q_cmd.action == ACT_START);
    act       = is_start || line_active;
    stp       = is_start ? q_cmd.steep       : steep_line;
    neg       = is_start ? q_cmd.minor_neg   : minor_step_negative;
    wx        = is_start ? q_cmd.x0          : cur_x;
    wy        = is_start ? q_cmd.y0          : cur_y;
    wend      = is_start ? q_cmd.major_end   : major_end;
    wmaj      = is_start ? q_cmd.major_delta : major_delta;
    wmin      = is_start ? q_cmd.minor_delta : minor_delta;
    wd        = is_start ? q_cmd.d0          : decision_term;
    wcol      = is_start ? q_cmd.colour      : line_colour;
    major_cur = stp ? wy : wx;
    last      = (major_cur == wend);
    bump      = !wd[D_BITS-1] && (wd != '0);
    d_next    = wd + twice(wmin) - (bump ? twice(wmaj) : dterm_t'(0));
    x_next    = wx;
    y_next    = wy;
    if (stp) begin
      y_next = wy + COORD_BITS'(1);
      if (bump) begin
        x_next = neg ? wx - COORD_BITS'(1) : wx + COORD_BITS'(1);
      end
    end else begin
      x_next = wx + COORD_BITS'(1);
      if (bump) begin
        y_next = neg ? wy - COORD_BITS'(1) : wy + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid_out         <= 1'b0;
      line_active         <= 1'b0;
      steep_line          <= 1'b0;
      cur_x               <= '0;
      cur_y               <= '0;
      major_end           <= '0;
      major_delta         <= '0;
      minor_delta         <= '0;
      minor_step_negative <= 1'b0;
      decision_term       <= '0;
      line_colour         <= '0;
    end else begin
      q_valid_out <= q_pop || (q_valid_out && !m_tready);
      if (q_pop) begin
        if (is_start) begin
          steep_line          <= q_cmd.steep;
          major_end           <= q_cmd.major_end;
          major_delta         <= q_cmd.major_delta;
          minor_delta         <= q_cmd.minor_delta;
          minor_step_negative <= q_cmd.minor_neg;
          line_colour         <= q_cmd.colour;
        end
        if (act) begin
          line_active   <= !last;
          cur_x         <= last ? wx : x_next;
          cur_y         <= last ? wy : y_next;
          decision_term <= last ? wd : d_next;
        end
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_pix    <= act;
      out_x      <= act ? wx : '0;
      out_y      <= act ? wy : '0;
      out_colour <= act ? wcol : '0;
      out_last   <= act && last;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lpg_checker.sv
// ---------------------------------------------------------------------------
// lpg_checker
// Port-level checks on the pixel output of the line pixel generator.
// ---------------------------------------------------------------------------
`default_nettype none

`include "line_pixel_generator_defines.svh"

module lpg_checker
  import lpg_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [OUT_DATA_BITS-1:0] m_tdata,
  input wire logic                     m_tuser,
  input wire logic                     m_tlast
);

  // a stalled transaction stays put
  `LPG_ASSERT(a_out_hold,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast),
    "output changed while stalled")

  // an invalid result carries nothing
  `LPG_ASSERT(a_invalid_zero,
    m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast,
    "invalid result not cleared")

  // nothing is offered straight after reset
  `LPG_ASSERT_ALWAYS(a_reset_idle, $past(rst) && !rst |-> !m_tvalid, "output valid after reset")

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);

`default_nettype wire
